// ===== rtl/linear_move_interpolator_assert.svh =====
// Assertion macros for the linear move interpolator.
`ifndef LINEAR_MOVE_INTERPOLATOR_ASSERT_SVH
`define LINEAR_MOVE_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define LMI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define LMI_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LMI_ASSERT(lbl, prop, msg)
`define LMI_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/lmi_pkg.sv =====
// Shared types and constants of the linear move interpolator.
package lmi_pkg;
   localparam int FRAC_BITS = 8;
   localparam int COORD_W   = 19;
   localparam int DIFF_W    = COORD_W + 1;
   localparam int STEP_W    = COORD_W + 2;
   localparam int SQ_W      = 40;
   localparam int SCALE_W   = 20;
   localparam int PROD_W    = SQ_W + SCALE_W;
   localparam int ROOT_W    = PROD_W / 2;
   localparam int DIV_W     = 32;
   localparam int LEN_W     = 6;
   localparam int REG_W     = 10;
   localparam int REACH_W   = 11;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 1;

   localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GOAL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_JUMP = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE = 1'd1;

   localparam logic [REG_W-1:0]   SPEED_RST  = 10'd100;
   localparam logic [REG_W-1:0]   SLICE_RST  = 10'd20;
   localparam logic [SCALE_W-1:0] SCALE      = 20'd1000000;
   localparam logic [SQ_W-1:0]    NEAR_LIMIT = SQ_W'(1) << (2 * FRAC_BITS);

   localparam logic [LEN_W-1:0] DIV_LEN_WIDE = LEN_W'(ROOT_W);
   localparam logic [LEN_W-1:0] DIV_LEN_STEP = LEN_W'(DIFF_W);

   typedef struct packed {
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
      logic [LEN_W-1:0] len;
   } div_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_CHECK,
      ST_SCALE,
      ST_ROOT,
      ST_DIV_T,
      ST_DIV_N,
      ST_DIV_STEP,
      ST_EMIT
   } state_type;
endpackage

// ===== rtl/linear_move_interpolator.sv =====
// Three-axis straight-line move interpolator.
// Input channel req_: one word per tick, req_mode selects tick, set goal or
// jump; the goal fields are read for set goal and jump.
// Result channel rsp_: at most one word per input word, the commanded point,
// the time to reach it and a flag for a jump.
// Configuration port csr_: speed (index 0) and slice time (index 1), to be
// written while the block is idle; the block itself does not enforce this.
// A set-goal word gives no result. A jump goes straight to the emit state.
// A tick that moves passes through three squares, a check, a shift-add
// scaling, a root and five passes of the bit-serial divider before its
// result goes to the emit state.
// A tick within 1 mm of the goal ends in the check state with no result.
// req_stall is high while a word is being worked on.
// The result waits in an output register; the next word is taken while it
// waits, and a new result holds in the sequencer until the register frees.
// Reset clears position and goal to zero, speed to 100 and slice to 20.
module linear_move_interpolator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lmi_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [lmi_pkg::COORD_W-1:0]  req_goal_x,
   input  logic signed [lmi_pkg::COORD_W-1:0]  req_goal_y,
   input  logic signed [lmi_pkg::COORD_W-1:0]  req_goal_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [lmi_pkg::COORD_W-1:0]  rsp_cmd_x,
   output logic signed [lmi_pkg::COORD_W-1:0]  rsp_cmd_y,
   output logic signed [lmi_pkg::COORD_W-1:0]  rsp_cmd_z,
   output logic [lmi_pkg::REACH_W-1:0]         rsp_reach_ms,
   output logic                                rsp_direct,
   input  logic                                csr_write_en,
   input  logic [lmi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lmi_pkg::REG_W-1:0]           csr_data
);
   import lmi_pkg::*;

`include "linear_move_interpolator_assert.svh"

   localparam int MCNT_W = $clog2(SCALE_W);

   function automatic logic signed [COORD_W-1:0] sat_coord(logic signed [STEP_W-1:0] v);
      logic signed [STEP_W-1:0] hi;
      logic signed [STEP_W-1:0] lo;
      hi = STEP_W'((1 << (COORD_W - 1)) - 1);
      lo = -STEP_W'(1 << (COORD_W - 1));
      if (v > hi) return hi[COORD_W-1:0];
      if (v < lo) return lo[COORD_W-1:0];
      return v[COORD_W-1:0];
   endfunction

   state_type                  state_ff, state_in;
   logic [REG_W-1:0]           speed_ff, speed_in;
   logic [REG_W-1:0]           slice_ff, slice_in;
   logic signed [COORD_W-1:0]  pos_ff  [3];
   logic signed [COORD_W-1:0]  pos_in  [3];
   logic signed [COORD_W-1:0]  goal_ff [3];
   logic signed [COORD_W-1:0]  goal_in [3];
   logic signed [DIFF_W-1:0]   diff_ff [3];
   logic signed [DIFF_W-1:0]   diff_in [3];
   logic signed [COORD_W-1:0]  res_ff  [3];
   logic signed [COORD_W-1:0]  res_in  [3];
   logic [1:0]                 axis_ff, axis_in;
   logic [SQ_W-1:0]            sum_ff, sum_in;
   logic [PROD_W-1:0]          mcand_ff, mcand_in;
   logic [SCALE_W-1:0]         mplier_ff, mplier_in;
   logic [PROD_W-1:0]          acc_ff, acc_in;
   logic [MCNT_W-1:0]          mcnt_ff, mcnt_in;
   logic [ROOT_W:0]            n_ff, n_in;
   logic [REACH_W-1:0]         res_reach_ff, res_reach_in;
   logic                       res_direct_ff, res_direct_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0]  rsp_cmd_ff [3];
   logic signed [COORD_W-1:0]  rsp_cmd_in [3];
   logic [REACH_W-1:0]         rsp_reach_ff, rsp_reach_in;
   logic                       rsp_direct_ff, rsp_direct_in;

   logic                       accept;
   logic signed [2*DIFF_W-1:0] square;
   logic [REG_W-1:0]           speed_eff;
   logic [REG_W-1:0]           slice_eff;
   logic [ROOT_W-1:0]          move_ms;
   logic [DIFF_W-1:0]          mag;
   logic signed [STEP_W-1:0]   step;
   logic signed [STEP_W-1:0]   next_pos;
   logic                       root_start, root_done;
   logic [ROOT_W-1:0]          root;
   logic                       div_start, div_done;
   div_req_type                div_req;
   logic [DIV_W-1:0]           quotient;

   lmi_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (acc_in),
      .done     (root_done),
      .root     (root)
   );

   lmi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .req      (div_req),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign speed_eff = (speed_ff == '0) ? REG_W'(1) : speed_ff;
   assign slice_eff = (slice_ff == '0) ? REG_W'(1) : slice_ff;
   assign square    = diff_ff[axis_ff] * diff_ff[axis_ff];
   assign move_ms   = (quotient[ROOT_W-1:0] != '0) ? quotient[ROOT_W-1:0] - 1'b1 : '0;

   always_comb begin
      state_in      = state_ff;
      speed_in      = speed_ff;
      slice_in      = slice_ff;
      pos_in        = pos_ff;
      goal_in       = goal_ff;
      diff_in       = diff_ff;
      res_in        = res_ff;
      axis_in       = axis_ff;
      sum_in        = sum_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      acc_in        = acc_ff;
      mcnt_in       = mcnt_ff;
      n_in          = n_ff;
      res_reach_in  = res_reach_ff;
      res_direct_in = res_direct_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_reach_in  = rsp_reach_ff;
      rsp_direct_in = rsp_direct_ff;
      root_start    = 1'b0;
      div_start     = 1'b0;
      div_req       = '0;
      mag           = '0;
      step          = '0;
      next_pos      = '0;

      if (csr_write_en) begin
         case (csr_index)
            CSR_SPEED: speed_in = csr_data;
            CSR_SLICE: slice_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_GOAL: begin
                     goal_in[0] = req_goal_x;
                     goal_in[1] = req_goal_y;
                     goal_in[2] = req_goal_z;
                  end
                  MODE_JUMP: begin
                     goal_in[0]    = req_goal_x;
                     goal_in[1]    = req_goal_y;
                     goal_in[2]    = req_goal_z;
                     pos_in        = goal_in;
                     res_in        = goal_in;
                     res_reach_in  = '0;
                     res_direct_in = 1'b1;
                     state_in      = ST_EMIT;
                  end
                  MODE_TICK: begin
                     for (int i = 0; i < 3; i++) begin
                        diff_in[i] = DIFF_W'(goal_ff[i]) - DIFF_W'(pos_ff[i]);
                     end
                     sum_in   = '0;
                     axis_in  = '0;
                     state_in = ST_SQUARE;
                  end
                  default: ;
               endcase
            end
         end
         ST_SQUARE: begin
            sum_in = sum_ff + SQ_W'($unsigned(square));
            if (axis_ff == 2'd2) begin
               state_in = ST_CHECK;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            if (sum_ff <= NEAR_LIMIT) begin
               state_in = ST_IDLE;
            end else begin
               mcand_in  = PROD_W'(sum_ff);
               mplier_in = SCALE;
               acc_in    = '0;
               mcnt_in   = MCNT_W'(SCALE_W - 1);
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            // shift-add: one bit of the scale constant a cycle
            acc_in    = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;
            mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[SCALE_W-1:1]};
            mcnt_in   = mcnt_ff - 1'b1;
            if (mcnt_ff == '0) begin
               root_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               div_start        = 1'b1;
               div_req.dividend = {root, {(DIV_W - ROOT_W){1'b0}}};
               div_req.divisor  = DIV_W'(speed_eff) << FRAC_BITS;
               div_req.len      = DIV_LEN_WIDE;
               state_in         = ST_DIV_T;
            end
         end
         ST_DIV_T: begin
            if (div_done) begin
               div_start        = 1'b1;
               div_req.dividend = {move_ms, {(DIV_W - ROOT_W){1'b0}}};
               div_req.divisor  = DIV_W'(slice_eff);
               div_req.len      = DIV_LEN_WIDE;
               state_in         = ST_DIV_N;
            end
         end
         ST_DIV_N: begin
            if (div_done) begin
               n_in             = (ROOT_W + 1)'(quotient[ROOT_W-1:0]) + 1'b1;
               axis_in          = '0;
               mag              = diff_ff[0][DIFF_W-1] ? DIFF_W'(-diff_ff[0]) : DIFF_W'(diff_ff[0]);
               div_start        = 1'b1;
               div_req.dividend = {mag, {(DIV_W - DIFF_W){1'b0}}};
               div_req.divisor  = DIV_W'(n_in);
               div_req.len      = DIV_LEN_STEP;
               state_in         = ST_DIV_STEP;
            end
         end
         ST_DIV_STEP: begin
            if (div_done) begin
               step = diff_ff[axis_ff][DIFF_W-1] ? -STEP_W'(quotient[DIFF_W-1:0])
                                                 : STEP_W'(quotient[DIFF_W-1:0]);
               next_pos = STEP_W'(pos_ff[axis_ff]) + step;
               pos_in[axis_ff] = next_pos[COORD_W-1:0];
               res_in[axis_ff] = (n_ff != (ROOT_W + 1)'(1)) ? sat_coord(next_pos + step)
                                                           : next_pos[COORD_W-1:0];
               if (axis_ff == 2'd2) begin
                  res_reach_in  = (n_ff != (ROOT_W + 1)'(1)) ? {slice_eff, 1'b0}
                                                             : REACH_W'(slice_eff);
                  res_direct_in = 1'b0;
                  state_in      = ST_EMIT;
               end else begin
                  axis_in          = axis_ff + 1'b1;
                  mag              = diff_ff[axis_in][DIFF_W-1] ? DIFF_W'(-diff_ff[axis_in])
                                                                : DIFF_W'(diff_ff[axis_in]);
                  div_start        = 1'b1;
                  div_req.dividend = {mag, {(DIV_W - DIFF_W){1'b0}}};
                  div_req.divisor  = DIV_W'(n_ff);
                  div_req.len      = DIV_LEN_STEP;
               end
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_cmd_in    = res_ff;
               rsp_reach_in  = res_reach_ff;
               rsp_direct_in = res_direct_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         speed_ff     <= SPEED_RST;
         slice_ff     <= SLICE_RST;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i]  <= '0;
            goal_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         speed_ff     <= speed_in;
         slice_ff     <= slice_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         goal_ff      <= goal_in;
      end
      diff_ff       <= diff_in;
      res_ff        <= res_in;
      axis_ff       <= axis_in;
      sum_ff        <= sum_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      acc_ff        <= acc_in;
      mcnt_ff       <= mcnt_in;
      n_ff          <= n_in;
      res_reach_ff  <= res_reach_in;
      res_direct_ff <= res_direct_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_reach_ff  <= rsp_reach_in;
      rsp_direct_ff <= rsp_direct_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cmd_x    = rsp_cmd_ff[0];
   assign rsp_cmd_y    = rsp_cmd_ff[1];
   assign rsp_cmd_z    = rsp_cmd_ff[2];
   assign rsp_reach_ms = rsp_reach_ff;
   assign rsp_direct   = rsp_direct_ff;

   `LMI_ASSERT_ALWAYS(a_reset_drops_word, reset |=> !rsp_valid, "result word after reset")
   `LMI_ASSERT(a_jump_zero_time, rsp_valid && rsp_direct |-> rsp_reach_ms == '0,
               "jump word with nonzero time")
   `LMI_ASSERT(a_move_has_time, rsp_valid && !rsp_direct |-> rsp_reach_ms != '0,
               "move word with zero time")
   `LMI_ASSERT(a_word_from_emit, rsp_valid && !$past(rsp_valid) |-> $past(state_ff == ST_EMIT),
               "result word raised outside emit")
endmodule

// ===== rtl/lmi_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module lmi_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  lmi_pkg::div_req_type       req,
   output logic                       done,
   output logic [lmi_pkg::DIV_W-1:0]  quotient
);
   import lmi_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [DIV_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_W:0]     part;
   logic [DIV_W:0]     diff;
   logic               fits;

   always_comb begin
      part    = {rem_ff, quo_ff[DIV_W-1]};
      diff    = part - {1'b0, dvs_ff};
      fits    = part >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = req.len;
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : part[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == LEN_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== rtl/lmi_isqrt.sv =====
// Digit-serial integer square root, two radicand bits per cycle.
module lmi_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lmi_pkg::PROD_W-1:0]  radicand,
   output logic                        done,
   output logic [lmi_pkg::ROOT_W-1:0]  root
);
   import lmi_pkg::*;

   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PROD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [REM_W+1:0]   part;
   logic [REM_W+1:0]   trial;
   logic               fits;

   always_comb begin
      part    = {rem_ff, rad_ff[PROD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      fits    = part >= trial;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ROOT_W);
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? REM_W'(part - trial) : part[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], fits};
         rad_in  = {rad_ff[PROD_W-3:0], 2'b00};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== sim/linear_move_interpolator_test.sv =====
// Self-checking testbench for the three-axis linear move interpolator.
module linear_move_interpolator_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lmi_pkg::*;

   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [REACH_W-1:0]        reach;
      logic                      direct;
   } cmd_word_type;

   class move_scoreboard;
      longint px, py, pz, gx, gy, gz;
      longint unsigned speed, slice;
      cmd_word_type expected[$];
      int errors, checked;

      function new();
         px = 0; py = 0; pz = 0; gx = 0; gy = 0; gz = 0;
         speed = SPEED_RST; slice = SLICE_RST;
         errors = 0; checked = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
         if (idx == CSR_SPEED) speed = val;
         else slice = val;
      endfunction

      function longint unsigned root(longint unsigned v);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      function logic signed [COORD_W-1:0] clip(longint v);
         if (v > 262143) v = 262143;
         if (v < -262144) v = -262144;
         return COORD_W'(v);
      endfunction

      // advance the model by one accepted word
      function void note(logic [MODE_W-1:0] mode, longint x, longint y, longint z);
         longint dx, dy, dz, n, sx, sy, sz;
         longint unsigned s, t, mv, spd, slc;
         cmd_word_type w;
         if (mode == MODE_GOAL || mode == MODE_JUMP) begin
            gx = x; gy = y; gz = z;
            if (mode == MODE_JUMP) begin
               px = x; py = y; pz = z;
               w.x = clip(px); w.y = clip(py); w.z = clip(pz);
               w.reach = '0; w.direct = 1'b1;
               expected.push_back(w);
            end
            return;
         end
         if (mode != MODE_TICK) return;
         dx = gx - px; dy = gy - py; dz = gz - pz;
         s = dx * dx + dy * dy + dz * dz;
         if (s <= (64'd1 << (2 * FRAC_BITS))) return;
         spd = (speed != 0) ? speed : 1;
         slc = (slice != 0) ? slice : 1;
         t = root(s * 1000000) / (spd << FRAC_BITS);
         mv = (t != 0) ? t - 1 : 0;
         n = longint'(mv / slc) + 1;
         sx = dx / n; sy = dy / n; sz = dz / n;
         px += sx; py += sy; pz += sz;
         if (n != 1) begin
            w.x = clip(px + sx); w.y = clip(py + sy); w.z = clip(pz + sz);
            w.reach = REACH_W'(slc * 2);
         end else begin
            w.x = clip(px); w.y = clip(py); w.z = clip(pz);
            w.reach = REACH_W'(slc);
         end
         w.direct = 1'b0;
         expected.push_back(w);
      endfunction

      function void check(cmd_word_type got);
         cmd_word_type w;
         if (expected.size() == 0) begin
            $error("unexpected result word x=%0d y=%0d z=%0d", got.x, got.y, got.z);
            errors++;
            return;
         end
         w = expected.pop_front();
         checked++;
         if (got.x !== w.x) begin
            $error("cmd_x expected %0d got %0d", w.x, got.x); errors++;
         end
         if (got.y !== w.y) begin
            $error("cmd_y expected %0d got %0d", w.y, got.y); errors++;
         end
         if (got.z !== w.z) begin
            $error("cmd_z expected %0d got %0d", w.z, got.z); errors++;
         end
         if (got.reach !== w.reach) begin
            $error("reach_ms expected %0d got %0d", w.reach, got.reach); errors++;
         end
         if (got.direct !== w.direct) begin
            $error("direct expected %0d got %0d", w.direct, got.direct); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [MODE_W-1:0] req_mode = MODE_TICK;
   logic signed [COORD_W-1:0] req_goal_x = '0, req_goal_y = '0, req_goal_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [COORD_W-1:0] rsp_cmd_x, rsp_cmd_y, rsp_cmd_z;
   logic [REACH_W-1:0] rsp_reach_ms;
   logic rsp_direct;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SPEED;
   logic [REG_W-1:0] csr_data = '0;

   move_scoreboard sb = new();
   bit idle_on = 1'b1;
   bit hold_req = 1'b0;
   int hold_count = 0;
   int quiet_cycles = 0;
   int sent = 0;
   longint near_x = 0, near_y = 0, near_z = 0;

   always #1 clock = ~clock;

   linear_move_interpolator u_dut (.*);

   // result side: check, then choose next stall
   always @(posedge clock) begin
      cmd_word_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.x = rsp_cmd_x; got.y = rsp_cmd_y; got.z = rsp_cmd_z;
         got.reach = rsp_reach_ms; got.direct = rsp_direct;
         sb.check(got);
      end
      if (hold_req) begin
         hold_req = 1'b0;
         hold_count = 600;
      end
      if (hold_count > 0) begin
         hold_count--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 28);
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send(logic [MODE_W-1:0] mode, longint x, longint y, longint z);
      if (idle_on && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_goal_x <= COORD_W'(x);
      req_goal_y <= COORD_W'(y);
      req_goal_z <= COORD_W'(z);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note(mode, COORD_W'(x) , COORD_W'(y), COORD_W'(z));
      if (mode != MODE_SPARE) sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected.size() != 0) @(posedge clock);
   endtask

   // write only once idle; a tick without result may still be running
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      drain();
      repeat (20) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   function automatic longint pick_coord(longint near);
      longint v;
      case ($urandom_range(5))
         0: v = $signed(COORD_W'($urandom));
         1: v = $urandom_range(1) ? 262143 : -262144;
         2: v = near + $signed(10'($urandom));
         3: v = near + $signed(16'($urandom));
         default: v = near + $signed(20'($urandom));
      endcase
      if (v > 262143) v = 262143;
      if (v < -262144) v = -262144;
      return v;
   endfunction

   task automatic random_move();
      longint x, y, z;
      x = pick_coord(near_x); y = pick_coord(near_y); z = pick_coord(near_z);
      if ($urandom_range(99) < 15) begin
         // noise: any mode, any goal
         send(MODE_W'($urandom), $signed(COORD_W'($urandom)),
              $signed(COORD_W'($urandom)), $signed(COORD_W'($urandom)));
         return;
      end
      send($urandom_range(1) ? MODE_JUMP : MODE_GOAL, x, y, z);
      near_x = x; near_y = y; near_z = z;
      x = pick_coord(near_x); y = pick_coord(near_y); z = pick_coord(near_z);
      send(MODE_GOAL, x, y, z);
      repeat ($urandom_range(2, 20)) send(MODE_TICK, 0, 0, 0);
   endtask

   initial begin
      logic [REG_W-1:0] speeds[6] = '{10'd100, 10'd1, 10'd1000, 10'd0, 10'd1023, 10'd37};
      logic [REG_W-1:0] slices[6] = '{10'd20, 10'd1000, 10'd1, 10'd1023, 10'd0, 10'd5};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, exact 1 mm boundary, spare mode, short move
      send(MODE_JUMP, 262143, 262143, 262143);
      send(MODE_GOAL, -262144, -262144, -262144);
      repeat (4) send(MODE_TICK, 0, 0, 0);
      send(MODE_JUMP, 0, 0, 0);
      send(MODE_GOAL, 0, 0, 256);
      send(MODE_TICK, 0, 0, 0);
      send(MODE_GOAL, 0, 0, 257);
      send(MODE_TICK, 0, 0, 0);
      send(MODE_SPARE, 1000, 1000, 1000);
      send(MODE_TICK, 0, 0, 0);
      send(MODE_GOAL, -181, 181, 0);
      send(MODE_TICK, 0, 0, 0);
      send(MODE_JUMP, -262144, 262143, -1);
      send(MODE_GOAL, 262143, -262144, 0);
      repeat (3) send(MODE_TICK, 0, 0, 0);

      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_SPEED, speeds[ph]);
         write_reg(CSR_SLICE, slices[ph]);
         idle_on = (ph != 2);
         while (sent < 40 + (ph + 1) * 330) begin
            random_move();
            if ($urandom_range(99) < 3) hold_req = 1'b1;
            if ($urandom_range(99) < 3) drain();
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d words over six speed and slice settings (extremes and zero included);",
               sent);
      $display("checked %0d result words with %0d mismatches.", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.expected.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ===== linear_move_interpolator.f =====
+incdir+rtl
rtl/lmi_pkg.sv
rtl/lmi_div.sv
rtl/lmi_isqrt.sv
rtl/linear_move_interpolator.sv
sim/linear_move_interpolator_test.sv
